>>> rtl/vector_to_pitch_yaw_unit_assert.svh
// Assertion macros used by the checker file v2py_chk.sv.
`ifndef VECTOR_TO_PITCH_YAW_UNIT_ASSERT_SVH
`define VECTOR_TO_PITCH_YAW_UNIT_ASSERT_SVH

// same-cycle implication
`define V2PY_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("v2py check failed");

// next-cycle implication
`define V2PY_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("v2py check failed");

`endif

>>> rtl/v2py_pkg.sv
`default_nettype none
package v2py_pkg;

	localparam int MAG_W      = 32;
	localparam int SQ_W       = 64;
	localparam int ROOT_W     = 32;
	localparam int NORM_W     = 41;
	localparam int CX_W       = 44;
	localparam int CZ_W       = 32;
	localparam int ANG_W      = 31;
	localparam int FULL_W     = 33;
	localparam int ANG_FRAC   = 24;

	localparam int ISQ_STAGES  = 16;
	localparam int CORD_STEPS  = 25;
	localparam int CORD_PER    = 3;
	localparam int CORD_STAGES = (CORD_STEPS + CORD_PER - 1) / CORD_PER;
	localparam int NORM_LAT    = 2;
	localparam int CORD_LAT    = NORM_LAT + CORD_STAGES + 1;
	localparam int FIX_LAT     = 2;

	localparam logic [MAG_W-1:0]  MAG_LIMIT = 32'h8000_0000;
	localparam logic [ANG_W-1:0]  DEG90     = 31'd1509949440;
	localparam logic [31:0]       DEG180    = 32'd3019898880;
	localparam logic [FULL_W-1:0] DEG360    = 33'd6039797760;

	// atan(2^-i) in degrees, 24 fraction bits
	localparam logic [29:0] STEP_ANGLE [CORD_STEPS] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
		30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
		30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
		30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
		30'd917,       30'd458,       30'd229,       30'd115,       30'd57
	};

	typedef struct packed {
		logic a_neg;
		logic a_nz;
		logic b_neg;
		logic b_nz;
	} quad_ctl_t;

endpackage
`default_nettype wire

>>> rtl/v2py_isqrt.sv
`default_nettype none
module v2py_isqrt
	import v2py_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [SQ_W-1:0]   sq,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] rem_s [ISQ_STAGES-1];
	logic [SQ_W-1:0] res_s [ISQ_STAGES];
	logic [SQ_W-1:0] rem_in [ISQ_STAGES];
	logic [SQ_W-1:0] res_in [ISQ_STAGES];
	logic [SQ_W-1:0] rem_d [ISQ_STAGES];
	logic [SQ_W-1:0] res_d [ISQ_STAGES];

	for (genvar g = 0; g < ISQ_STAGES; g++) begin : g_stg
		if (g == 0) begin : g_first
			assign rem_in[g] = sq;
			assign res_in[g] = '0;
		end else begin : g_next
			assign rem_in[g] = rem_s[g-1];
			assign res_in[g] = res_s[g-1];
		end

		// two restoring digit steps per stage
		always_comb begin
			logic [SQ_W-1:0] r, q, b;
			r = rem_in[g];
			q = res_in[g];
			for (int j = 0; j < 2; j++) begin
				b = SQ_W'(1) << (62 - 2 * (2 * g + j));
				if (r >= q + b) begin
					r = r - (q + b);
					q = (q >> 1) + b;
				end else begin
					q = q >> 1;
				end
			end
			rem_d[g] = r;
			res_d[g] = q;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				res_s[g] <= res_d[g];
			end
		end

		if (g < ISQ_STAGES - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= rem_d[g];
				end
			end
		end
	end

	assign root = res_s[ISQ_STAGES-1][ROOT_W-1:0];

endmodule
`default_nettype wire

>>> rtl/v2py_cordic.sv
`default_nettype none
module v2py_cordic
	import v2py_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [MAG_W-1:0] a,
	input  logic [MAG_W-1:0] b,
	input  quad_ctl_t        ctl_in,
	output logic [ANG_W-1:0] ang,
	output quad_ctl_t        ctl_out
);

	logic [NORM_W-1:0] na_d1, nb_d1, na_s1, nb_s1;
	logic [NORM_W-1:0] na_d2, nb_d2, na_s2, nb_s2;
	quad_ctl_t         c_s1, c_s2;

	// left-justify so the larger operand lands in [2^40, 2^41)
	always_comb begin
		logic [NORM_W-1:0] ae, be, m;
		ae = NORM_W'(a);
		be = NORM_W'(b);
		m  = (ae >= be) ? ae : be;
		for (int j = 0; j < 3; j++) begin
			if (m < (NORM_W'(1) << (NORM_W - (32 >> j)))) begin
				ae = ae << (32 >> j);
				be = be << (32 >> j);
				m  = m << (32 >> j);
			end
		end
		na_d1 = ae;
		nb_d1 = be;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s1 <= na_d1;
			nb_s1 <= nb_d1;
			c_s1  <= ctl_in;
		end
	end

	always_comb begin
		logic [NORM_W-1:0] ae, be, m;
		ae = na_s1;
		be = nb_s1;
		m  = (ae >= be) ? ae : be;
		for (int j = 0; j < 3; j++) begin
			if (m < (NORM_W'(1) << (NORM_W - (4 >> j)))) begin
				ae = ae << (4 >> j);
				be = be << (4 >> j);
				m  = m << (4 >> j);
			end
		end
		na_d2 = ae;
		nb_d2 = be;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s2 <= na_d2;
			nb_s2 <= nb_d2;
			c_s2  <= c_s1;
		end
	end

	logic signed [CX_W-1:0] x_s [CORD_STAGES-1];
	logic signed [CX_W-1:0] y_s [CORD_STAGES-1];
	logic signed [CZ_W-1:0] z_s [CORD_STAGES];
	quad_ctl_t              c_s [CORD_STAGES];
	logic signed [CX_W-1:0] x_in [CORD_STAGES];
	logic signed [CX_W-1:0] y_in [CORD_STAGES];
	logic signed [CZ_W-1:0] z_in [CORD_STAGES];
	quad_ctl_t              c_in [CORD_STAGES];
	logic signed [CX_W-1:0] x_d [CORD_STAGES];
	logic signed [CX_W-1:0] y_d [CORD_STAGES];
	logic signed [CZ_W-1:0] z_d [CORD_STAGES];

	for (genvar g = 0; g < CORD_STAGES; g++) begin : g_stg
		if (g == 0) begin : g_first
			assign x_in[g] = CX_W'(na_s2);
			assign y_in[g] = CX_W'(nb_s2);
			assign z_in[g] = '0;
			assign c_in[g] = c_s2;
		end else begin : g_next
			assign x_in[g] = x_s[g-1];
			assign y_in[g] = y_s[g-1];
			assign z_in[g] = z_s[g-1];
			assign c_in[g] = c_s[g-1];
		end

		// vectoring rotations, drive y toward zero
		always_comb begin
			logic signed [CX_W-1:0] x, y, dx, dy;
			logic signed [CZ_W-1:0] z;
			x = x_in[g];
			y = y_in[g];
			z = z_in[g];
			for (int j = 0; j < CORD_PER; j++) begin
				if (g * CORD_PER + j < CORD_STEPS) begin
					dx = y >>> (g * CORD_PER + j);
					dy = x >>> (g * CORD_PER + j);
					if (y > 0) begin
						x = x + dx;
						y = y - dy;
						z = z + $signed({2'b00, STEP_ANGLE[g * CORD_PER + j]});
					end else begin
						x = x - dx;
						y = y + dy;
						z = z - $signed({2'b00, STEP_ANGLE[g * CORD_PER + j]});
					end
				end
			end
			x_d[g] = x;
			y_d[g] = y;
			z_d[g] = z;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				z_s[g] <= z_d[g];
				c_s[g] <= c_in[g];
			end
		end

		if (g < CORD_STAGES - 1) begin : g_xy
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[g] <= x_d[g];
					y_s[g] <= y_d[g];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_out <= c_s[CORD_STAGES-1];
			if (!c_s[CORD_STAGES-1].b_nz) begin
				ang <= '0;
			end else if (!c_s[CORD_STAGES-1].a_nz) begin
				ang <= DEG90;
			end else if (z_s[CORD_STAGES-1] < 0) begin
				ang <= '0;
			end else if (z_s[CORD_STAGES-1] > $signed({1'b0, DEG90})) begin
				ang <= DEG90;
			end else begin
				ang <= z_s[CORD_STAGES-1][ANG_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/v2py_afix.sv
`default_nettype none
module v2py_afix
	import v2py_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [ANG_W-1:0]       ang,
	input  quad_ctl_t              ctl,
	output logic [9+FRAC_BITS-1:0] deg
);

	localparam int OUT_W = 9 + FRAC_BITS;
	localparam int SH    = ANG_FRAC - FRAC_BITS;
	localparam logic [FULL_W:0] HALF = (34'd1 << SH) >> 1;
	localparam logic [FULL_W:0] WRAP = 34'd360 << FRAC_BITS;

	logic [FULL_W-1:0] full_s1;

	// restore quadrant: mirror for negative first operand, negate for negative second
	always_ff @(posedge clk) begin
		logic [31:0] u;
		if (en) begin
			u = (ctl.a_neg && ctl.a_nz) ? DEG180 - 32'(ang) : 32'(ang);
			if (ctl.b_neg && ctl.b_nz && u != '0) begin
				full_s1 <= DEG360 - FULL_W'(u);
			end else begin
				full_s1 <= FULL_W'(u);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [FULL_W:0] vr;
		if (en) begin
			vr = ({1'b0, full_s1} + HALF) >> SH;
			if (vr >= WRAP) begin
				vr = vr - WRAP;
			end
			deg <= vr[OUT_W-1:0];
		end
	end

endmodule
`default_nettype wire

>>> rtl/vector_to_pitch_yaw_unit.sv
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while the output register waits for out_ready.
// The 16-stage square root and the 12-stage CORDIC set the depth.
// Reset (arst_n low, asynchronous) clears only the valid bits; data registers keep state.
`default_nettype none
module vector_to_pitch_yaw_unit
	import v2py_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] vec_x,
	input  logic signed [COORD_WIDTH-1:0] vec_y,
	input  logic signed [COORD_WIDTH-1:0] vec_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [9+FRAC_BITS-1:0]        pitch_deg,
	output logic [9+FRAC_BITS-1:0]        yaw_deg
);

	localparam int OUT_W    = 9 + FRAC_BITS;
	localparam int EW       = (COORD_WIDTH > MAG_W) ? COORD_WIDTH : MAG_W;
	localparam int PS_MAX   = EW - MAG_W;
	localparam int OVR_LAT  = CORD_LAT + FIX_LAT;
	localparam int PIPE_LAT = 4 + ISQ_STAGES + OVR_LAT + 1;
	localparam logic [OUT_W-1:0] PITCH_UP   = OUT_W'(270) << FRAC_BITS;
	localparam logic [OUT_W-1:0] PITCH_DOWN = OUT_W'(90) << FRAC_BITS;

	typedef struct packed {
		logic             xn;
		logic             yn;
		logic             zn;
		logic             zero_xy;
		logic             z_pos;
		logic [MAG_W-1:0] xm;
		logic [MAG_W-1:0] ym;
		logic [MAG_W-1:0] zm;
	} side_t;

	logic                en;
	logic [PIPE_LAT-1:0] vld_q;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// stage 1: sign and magnitude
	logic                   xn_s1, yn_s1, zn_s1, zero_xy_s1, z_pos_s1;
	logic [COORD_WIDTH-1:0] xm_s1, ym_s1, zm_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s1      <= vec_x[COORD_WIDTH-1];
			yn_s1      <= vec_y[COORD_WIDTH-1];
			zn_s1      <= vec_z[COORD_WIDTH-1];
			xm_s1      <= vec_x[COORD_WIDTH-1] ? (~vec_x + 1'b1) : vec_x;
			ym_s1      <= vec_y[COORD_WIDTH-1] ? (~vec_y + 1'b1) : vec_y;
			zm_s1      <= vec_z[COORD_WIDTH-1] ? (~vec_z + 1'b1) : vec_z;
			zero_xy_s1 <= (vec_x == '0) && (vec_y == '0);
			z_pos_s1   <= !vec_z[COORD_WIDTH-1] && (vec_z != '0);
		end
	end

	// stage 2: common right shift so no magnitude exceeds 2^31
	side_t            sd_s2;
	logic [MAG_W-1:0] xp, yp, zp;

	always_comb begin
		logic [EW-1:0] xe, ye, ze;
		xe = EW'(xm_s1);
		ye = EW'(ym_s1);
		ze = EW'(zm_s1);
		xp = '0;
		yp = '0;
		zp = '0;
		for (int s = PS_MAX; s >= 0; s--) begin
			if ((xe >> s) <= EW'(MAG_LIMIT) && (ye >> s) <= EW'(MAG_LIMIT) &&
			    (ze >> s) <= EW'(MAG_LIMIT)) begin
				xp = MAG_W'(xe >> s);
				yp = MAG_W'(ye >> s);
				zp = MAG_W'(ze >> s);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2 <= '{xn: xn_s1, yn: yn_s1, zn: zn_s1, zero_xy: zero_xy_s1,
			           z_pos: z_pos_s1, xm: xp, ym: yp, zm: zp};
		end
	end

	// stages 3 and 4: squares, then their sum
	side_t           sd_s3, sd_s4;
	logic [SQ_W-1:0] xsq_s3, ysq_s3, sum_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			xsq_s3 <= SQ_W'(sd_s2.xm) * SQ_W'(sd_s2.xm);
			ysq_s3 <= SQ_W'(sd_s2.ym) * SQ_W'(sd_s2.ym);
			sd_s3  <= sd_s2;
			sum_s4 <= xsq_s3 + ysq_s3;
			sd_s4  <= sd_s3;
		end
	end

	logic [ROOT_W-1:0] root;
	side_t             sd_dly [ISQ_STAGES];

	v2py_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.sq   (sum_s4),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_dly[0] <= sd_s4;
			for (int i = 1; i < ISQ_STAGES; i++) begin
				sd_dly[i] <= sd_dly[i-1];
			end
		end
	end

	side_t     sd_r;
	quad_ctl_t yaw_ctl, pitch_ctl, yaw_ctl_o, pitch_ctl_o;
	logic [ANG_W-1:0] yaw_ang, pitch_ang;

	assign sd_r      = sd_dly[ISQ_STAGES-1];
	assign yaw_ctl   = '{a_neg: sd_r.xn, a_nz: sd_r.xm != '0,
	                     b_neg: sd_r.yn, b_nz: sd_r.ym != '0};
	assign pitch_ctl = '{a_neg: 1'b0, a_nz: root != '0,
	                     b_neg: !sd_r.zn, b_nz: sd_r.zm != '0};

	v2py_cordic u_cordic_yaw (
		.clk     (clk),
		.en      (en),
		.a       (sd_r.xm),
		.b       (sd_r.ym),
		.ctl_in  (yaw_ctl),
		.ang     (yaw_ang),
		.ctl_out (yaw_ctl_o)
	);

	v2py_cordic u_cordic_pitch (
		.clk     (clk),
		.en      (en),
		.a       (root),
		.b       (sd_r.zm),
		.ctl_in  (pitch_ctl),
		.ang     (pitch_ang),
		.ctl_out (pitch_ctl_o)
	);

	logic [OUT_W-1:0] yaw_fix, pitch_fix;

	v2py_afix #(.FRAC_BITS(FRAC_BITS)) u_afix_yaw (
		.clk (clk),
		.en  (en),
		.ang (yaw_ang),
		.ctl (yaw_ctl_o),
		.deg (yaw_fix)
	);

	v2py_afix #(.FRAC_BITS(FRAC_BITS)) u_afix_pitch (
		.clk (clk),
		.en  (en),
		.ang (pitch_ang),
		.ctl (pitch_ctl_o),
		.deg (pitch_fix)
	);

	// zero horizontal part overrides both angles at the output
	logic [1:0] ovr_dly [OVR_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			ovr_dly[0] <= {sd_r.zero_xy, sd_r.z_pos};
			for (int i = 1; i < OVR_LAT; i++) begin
				ovr_dly[i] <= ovr_dly[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovr_dly[OVR_LAT-1][1]) begin
				yaw_deg   <= '0;
				pitch_deg <= ovr_dly[OVR_LAT-1][0] ? PITCH_UP : PITCH_DOWN;
			end else begin
				yaw_deg   <= yaw_fix;
				pitch_deg <= pitch_fix;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/v2py_chk.sv
`default_nettype none
`include "vector_to_pitch_yaw_unit_assert.svh"
module v2py_chk #(
	parameter int FRAC_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [9+FRAC_BITS-1:0] pitch_deg,
	input logic [9+FRAC_BITS-1:0] yaw_deg
);

	localparam int OUT_W = 9 + FRAC_BITS;
	localparam logic [OUT_W-1:0] LIM = OUT_W'(360) << FRAC_BITS;

	`V2PY_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pitch_deg) && $stable(yaw_deg))
	`V2PY_ASSERT_NOW(a_out_range, out_valid, pitch_deg < LIM && yaw_deg < LIM)
	`V2PY_ASSERT_NOW(a_in_ready, !out_valid || out_ready, in_ready)

endmodule

bind vector_to_pitch_yaw_unit v2py_chk #(.FRAC_BITS(FRAC_BITS)) u_v2py_chk (.*);
`default_nettype wire

>>> bench/tb_vector_to_pitch_yaw_unit.sv
`timescale 1ns / 1ps
`default_nettype none

class angle_scoreboard;
	logic [24:0] exp_pitch_q[$];
	logic [24:0] exp_yaw_q[$];
	int errors;
	int checked;

	static function longint shr_floor(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return ~((~v) >>> s);
	endfunction

	static function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// first-quadrant vectoring CORDIC, degrees with 24 fraction bits
	static function longint first_quad_angle(longint unsigned a, longint unsigned b);
		longint x, y, z, dx, dy;
		longint unsigned lim;
		longint atan_tab[25];
		atan_tab = '{754974720, 445687602, 235489088, 119537938, 60000934,
			30029717, 15018523, 7509720, 3754917, 1877466,
			938734, 469367, 234684, 117342, 58671,
			29335, 14668, 7334, 3667, 1833,
			917, 458, 229, 115, 57};
		lim = 64'd1 << 40;
		z = 0;
		if (b == 0)
			return 0;
		if (a == 0)
			return 64'd90 << 24;
		while (a < lim && b < lim) begin
			a <<= 1;
			b <<= 1;
		end
		x = a;
		y = b;
		for (int i = 0; i < 25; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end else begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > (64'd90 << 24))
			z = 64'd90 << 24;
		return z;
	endfunction

	static function logic [24:0] wrapped_angle(bit aneg, longint unsigned amag,
			bit bneg, longint unsigned bmag);
		longint t;
		longint unsigned v;
		t = first_quad_angle(amag, bmag);
		if (aneg && amag != 0)
			t = (64'd180 << 24) - t;
		if (bneg && bmag != 0)
			t = -t;
		if (t < 0)
			t += 64'd360 << 24;
		v = t;
		v = (v + 128) >> 8;
		if (v >= (64'd360 << 16))
			v -= 64'd360 << 16;
		return v[24:0];
	endfunction

	function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		bit xn, yn, zn;
		longint unsigned xm, ym, zm, r;
		logic [24:0] p, w;
		xn = x[31];
		yn = y[31];
		zn = z[31];
		xm = xn ? {32'd0, -x} : {32'd0, x};
		ym = yn ? {32'd0, -y} : {32'd0, y};
		zm = zn ? {32'd0, -z} : {32'd0, z};
		if (xm == 0) xm = xn ? 64'h8000_0000 : 0;
		if (ym == 0) ym = yn ? 64'h8000_0000 : 0;
		if (zm == 0) zm = zn ? 64'h8000_0000 : 0;
		if (xm == 0 && ym == 0) begin
			w = 0;
			p = (!zn && zm != 0) ? 25'd270 << 16 : 25'd90 << 16;
		end else begin
			while (xm > 64'h8000_0000 || ym > 64'h8000_0000 || zm > 64'h8000_0000) begin
				xm >>= 1;
				ym >>= 1;
				zm >>= 1;
			end
			r = int_sqrt(xm * xm + ym * ym);
			w = wrapped_angle(xn, xm, yn, ym);
			p = wrapped_angle(1'b0, r, !zn, zm);
		end
		exp_pitch_q.push_back(p);
		exp_yaw_q.push_back(w);
	endfunction

	function void check_angles(logic [24:0] p, logic [24:0] w);
		logic [24:0] ep, ew;
		if (exp_pitch_q.size() == 0) begin
			$display("%0t: unexpected result pitch=%0d yaw=%0d", $time, p, w);
			errors++;
			return;
		end
		ep = exp_pitch_q.pop_front();
		ew = exp_yaw_q.pop_front();
		checked++;
		if (p !== ep) begin
			$display("%0t: pitch_deg expected %0d actual %0d", $time, ep, p);
			errors++;
		end
		if (w !== ew) begin
			$display("%0t: yaw_deg expected %0d actual %0d", $time, ew, w);
			errors++;
		end
	endfunction
endclass

module tb_vector_to_pitch_yaw_unit;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] vec_x, vec_y, vec_z;
	logic out_valid;
	logic out_ready;
	logic [24:0] pitch_deg, yaw_deg;

	angle_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int sent;

	vector_to_pitch_yaw_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.pitch_deg(pitch_deg), .yaw_deg(yaw_deg)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// input acceptance and output checking on the same edge the DUT sees
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_vector(vec_x, vec_y, vec_z);
		if (arst_n && out_valid && out_ready)
			sb.check_angles(pitch_deg, yaw_deg);
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(255) - 128;
			2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
			3: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
			4: return 32'd0;
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.exp_pitch_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int n, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			send_vector(rand_coord(), rand_coord(), rand_coord());
			if (i % 64 == 63)
				send_idle_pct = (send_idle_pct == 0) ? idle_pct : 0;
		end
	endtask

	initial begin
		logic [31:0] ext[6];
		sb = new();
		sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// axes, zero vector, extremes, quadrants
		ext = '{32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
		send_vector(0, 0, 0);
		send_vector(0, 0, 32'h0001_0000);
		send_vector(0, 0, 32'hffff_0000);
		send_vector(32'h8000_0000, 0, 0);
		send_vector(0, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		for (int i = 0; i < 16; i++)
			send_vector(ext[$urandom_range(5)] ^ (i[0] ? 32'h0 : 32'h0),
				(i & 2) ? 32'hfff0_0000 : 32'h0010_0000,
				ext[i % 6]);
		send_vector(32'hffff_0000, 32'h0, 32'h0);
		send_vector(32'h0, 32'hffff_0000, 32'h0);
		drain();

		random_phase(300, 0, 0);
		random_phase(250, 57, 0);
		drain();
		random_phase(250, 0, 57);
		random_phase(250, 29, 29);
		drain();
		recv_stall_pct = 0;
		repeat (40) @(posedge clk);

		$display("Covered %0d vectors over idle/stall phases; %0d results compared.",
			sent, sb.checked);
		if (sb.errors == 0 && sb.exp_pitch_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

`default_nettype wire
